// ===== hdl/emac_pkg.sv =====
package emac_pkg;

	// Accumulator width of every running sum
	localparam int ACC_W  = 28;
	// Shared squarer operand and product widths
	localparam int MUL_W  = 30;
	localparam int PROD_W = 2 * MUL_W;
	// Square root unit: radicand and root widths
	localparam int SQ_W   = 58;
	localparam int RT_W   = SQ_W / 2;
	localparam int REM_W  = RT_W + 3;
	localparam int RTC_W  = $clog2(RT_W);

	// Result field widths
	localparam int E_SUM_W = 27;
	localparam int M2_W    = 57;
	localparam int MS_W    = 29;
	localparam int MT2_W   = 56;
	localparam int PT_W    = 28;

	// Head-of-queue control from front to back
	typedef struct packed {
		logic valid;
		logic kind;
		logic last;
		logic drop;
	} qctl_t;

	// Square root unit status
	typedef struct packed {
		logic busy;
		logic done;
	} rt_stat_t;

	localparam logic KIND_VISIBLE   = 1'b0;
	localparam logic KIND_INVISIBLE = 1'b1;

endpackage

// ===== hdl/emac_isqrt.sv =====
module emac_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [emac_pkg::SQ_W-1:0]  radicand,
	output emac_pkg::rt_stat_t         stat,
	output logic [emac_pkg::RT_W-1:0]  root
);

	logic [emac_pkg::SQ_W-1:0]  x_q;
	logic [emac_pkg::REM_W-1:0] rem_q;
	logic [emac_pkg::RT_W-1:0]  root_q;
	logic [emac_pkg::RTC_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [emac_pkg::REM_W-1:0] rem_sh;
	logic [emac_pkg::REM_W-1:0] trial;
	logic                       ge;

	// One root bit per cycle, restoring digit recurrence
	always_comb begin
		rem_sh = {rem_q[emac_pkg::REM_W-3:0], x_q[emac_pkg::SQ_W-1 -: 2]};
		trial  = emac_pkg::REM_W'({root_q, 2'b01});
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= emac_pkg::RTC_W'(emac_pkg::RT_W - 1);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[emac_pkg::RT_W-2:0], ge};
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

// ===== hdl/emac_front.sv =====
module emac_front #(
	parameter int MAX_VECTORS    = 16,
	parameter int COMPONENT_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [COMPONENT_BITS-2:0]        energy,
	input  logic signed [COMPONENT_BITS-1:0] mom_x,
	input  logic signed [COMPONENT_BITS-1:0] mom_y,
	input  logic signed [COMPONENT_BITS-1:0] mom_z,
	input  logic                             last_vector,
	output emac_pkg::qctl_t                  head,
	output logic [COMPONENT_BITS-2:0]        head_e,
	output logic signed [COMPONENT_BITS-1:0] head_px,
	output logic signed [COMPONENT_BITS-1:0] head_py,
	output logic signed [COMPONENT_BITS-1:0] head_pz,
	input  logic                             pop
);

	localparam int CNT_W = $clog2(MAX_VECTORS + 1);

	logic [CNT_W-1:0] count_q;
	logic             drop;
	logic             push;

	logic [COMPONENT_BITS-2:0]        e_mem  [2];
	logic signed [COMPONENT_BITS-1:0] px_mem [2];
	logic signed [COMPONENT_BITS-1:0] py_mem [2];
	logic signed [COMPONENT_BITS-1:0] pz_mem [2];
	logic                             kd_mem [2];
	logic                             ls_mem [2];
	logic                             dr_mem [2];
	logic                             wr_ptr_q;
	logic                             rd_ptr_q;
	logic [1:0]                       fill_q;

	// Classify: vectors past the event limit are marked for dropping
	assign drop     = count_q >= CNT_W'(MAX_VECTORS);
	assign in_stall = fill_q == 2'd2;
	assign push     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (last_vector)
				count_q <= '0;
			else if (!drop)
				count_q <= count_q + 1'b1;
		end
	end

	// Two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			e_mem[wr_ptr_q]  <= energy;
			px_mem[wr_ptr_q] <= mom_x;
			py_mem[wr_ptr_q] <= mom_y;
			pz_mem[wr_ptr_q] <= mom_z;
			kd_mem[wr_ptr_q] <= kind;
			ls_mem[wr_ptr_q] <= last_vector;
			dr_mem[wr_ptr_q] <= drop;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	assign head.valid = fill_q != '0;
	assign head.kind  = kd_mem[rd_ptr_q];
	assign head.last  = ls_mem[rd_ptr_q];
	assign head.drop  = dr_mem[rd_ptr_q];
	assign head_e     = e_mem[rd_ptr_q];
	assign head_px    = px_mem[rd_ptr_q];
	assign head_py    = py_mem[rd_ptr_q];
	assign head_pz    = pz_mem[rd_ptr_q];

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'd2) else $error("queue overfilled");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> fill_q != '0) else $error("pop from empty queue");
	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> fill_q == $past(fill_q) + 2'd1) else $error("fill count slip");

endmodule

// ===== hdl/emac_back.sv =====
module emac_back #(
	parameter int COMPONENT_BITS = 24
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  emac_pkg::qctl_t                             head,
	input  logic [COMPONENT_BITS-2:0]                   head_e,
	input  logic signed [COMPONENT_BITS-1:0]            head_px,
	input  logic signed [COMPONENT_BITS-1:0]            head_py,
	input  logic signed [COMPONENT_BITS-1:0]            head_pz,
	output logic                                        pop,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	output logic [emac_pkg::E_SUM_W-1:0]                energy_sum,
	output logic signed [emac_pkg::ACC_W-1:0]           px_sum,
	output logic signed [emac_pkg::ACC_W-1:0]           py_sum,
	output logic signed [emac_pkg::ACC_W-1:0]           pz_sum,
	output logic signed [emac_pkg::M2_W-1:0]            mass_squared,
	output logic signed [emac_pkg::MS_W-1:0]            mass_signed,
	output logic signed [emac_pkg::MT2_W-1:0]           transverse_mass_squared,
	output logic [emac_pkg::PT_W-1:0]                   transverse_momentum,
	output logic                                        overflow
);

	localparam int AW = emac_pkg::ACC_W;
	localparam int MW = emac_pkg::MUL_W;
	localparam int PW = emac_pkg::PROD_W;

	typedef enum logic [4:0] {
		S_IDLE, S_I0, S_I1, S_I2, S_I3,
		S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7,
		S_F8, S_F9, S_F9W, S_F10, S_F11, S_EMIT
	} state_t;

	state_t state_q;

	logic [AW-1:0]        tot_e_q;
	logic signed [AW-1:0] tot_px_q;
	logic signed [AW-1:0] tot_py_q;
	logic signed [AW-1:0] tot_pz_q;
	logic [AW-1:0]        vis_e_q;
	logic signed [AW-1:0] vis_pz_q;
	logic signed [AW-1:0] inv_q;
	logic                 drop_q;
	logic                 last_q;
	logic signed [MW-1:0] item_e_q;
	logic signed [MW-1:0] item_z_q;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] acc_q;
	logic signed [PW-1:0] pt_q;
	logic signed [PW-1:0] m2_q;
	logic signed [PW-1:0] mt2_q;
	logic signed [MW-1:0] et_q;
	logic signed [MW-1:0] mroot_q;
	logic                 neg_q;
	logic [emac_pkg::RT_W-1:0] ptr_q;

	logic signed [MW-1:0] mul_op;
	logic signed [PW-1:0] diff;
	logic signed [PW-1:0] rad_s;
	logic signed [PW-1:0] rad_mag;
	logic                 rt_start;
	logic [emac_pkg::SQ_W-1:0] rt_rad;
	emac_pkg::rt_stat_t   rt_stat;
	logic [emac_pkg::RT_W-1:0] rt_root;
	logic signed [MW-1:0] sroot;
	logic                 emit;

	emac_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rt_start),
		.radicand (rt_rad),
		.stat     (rt_stat),
		.root     (rt_root)
	);

	// Squarer operand select, one square per cycle
	always_comb begin
		case (state_q)
			S_I0:    mul_op = item_e_q;
			S_I1:    mul_op = item_z_q;
			S_F0:    mul_op = signed'(MW'(tot_e_q));
			S_F1:    mul_op = MW'(tot_px_q);
			S_F2:    mul_op = MW'(tot_py_q);
			S_F3:    mul_op = MW'(tot_pz_q);
			S_F4:    mul_op = signed'(MW'(vis_e_q));
			S_F5:    mul_op = MW'(vis_pz_q);
			S_F8:    mul_op = et_q;
			default: mul_op = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_op * mul_op;
	end

	// Root unit launch and radicand magnitude
	always_comb begin
		diff = acc_q - prod_q;
		case (state_q)
			S_F8:    rad_s = m2_q;
			S_F10:   rad_s = pt_q;
			default: rad_s = diff;
		endcase
		rad_mag  = (rad_s < 0) ? -rad_s : rad_s;
		rt_rad   = emac_pkg::SQ_W'(rad_mag);
		rt_start = (state_q == S_I2) || (state_q == S_F6) ||
		           (state_q == S_F8) || (state_q == S_F10);
		sroot    = neg_q ? -signed'(MW'(rt_root)) : signed'(MW'(rt_root));
	end

	assign pop  = (state_q == S_IDLE) && head.valid;
	assign emit = (state_q == S_EMIT) && (!out_valid || !out_stall);

	// Sequencer, sums and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tot_e_q   <= '0;
			tot_px_q  <= '0;
			tot_py_q  <= '0;
			tot_pz_q  <= '0;
			vis_e_q   <= '0;
			vis_pz_q  <= '0;
			inv_q     <= '0;
			drop_q    <= 1'b0;
			last_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// result beat loads on emit, drains when taken
			if (emit || (out_valid && !out_stall))
				out_valid <= emit;
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						last_q <= head.last;
						if (head.drop) begin
							drop_q  <= 1'b1;
							state_q <= head.last ? S_F0 : S_IDLE;
						end else begin
							tot_e_q  <= tot_e_q + AW'(head_e);
							tot_px_q <= tot_px_q + AW'(head_px);
							tot_py_q <= tot_py_q + AW'(head_py);
							tot_pz_q <= tot_pz_q + AW'(head_pz);
							if (head.kind == emac_pkg::KIND_INVISIBLE) begin
								item_e_q <= signed'(MW'(head_e));
								item_z_q <= MW'(head_pz);
								state_q  <= S_I0;
							end else begin
								vis_e_q  <= vis_e_q + AW'(head_e);
								vis_pz_q <= vis_pz_q + AW'(head_pz);
								state_q  <= head.last ? S_F0 : S_IDLE;
							end
						end
					end
				end
				S_I0: state_q <= S_I1;
				S_I1: begin
					acc_q   <= prod_q;
					state_q <= S_I2;
				end
				S_I2: begin
					neg_q   <= diff < 0;
					state_q <= S_I3;
				end
				S_I3: begin
					if (rt_stat.done) begin
						inv_q   <= inv_q + AW'(sroot);
						state_q <= last_q ? S_F0 : S_IDLE;
					end
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					acc_q   <= prod_q;
					state_q <= S_F2;
				end
				S_F2: begin
					pt_q    <= prod_q;
					state_q <= S_F3;
				end
				S_F3: begin
					pt_q    <= pt_q + prod_q;
					state_q <= S_F4;
				end
				S_F4: begin
					m2_q    <= acc_q - pt_q - prod_q;
					state_q <= S_F5;
				end
				S_F5: begin
					acc_q   <= prod_q;
					state_q <= S_F6;
				end
				S_F6: begin
					neg_q   <= diff < 0;
					state_q <= S_F7;
				end
				S_F7: begin
					if (rt_stat.done) begin
						et_q    <= sroot + MW'(inv_q);
						state_q <= S_F8;
					end
				end
				S_F8: begin
					neg_q   <= m2_q < 0;
					state_q <= S_F9;
				end
				S_F9: begin
					mt2_q   <= prod_q - pt_q;
					state_q <= S_F9W;
				end
				S_F9W: begin
					if (rt_stat.done) begin
						mroot_q <= sroot;
						state_q <= S_F10;
					end
				end
				S_F10: state_q <= S_F11;
				S_F11: begin
					if (rt_stat.done) begin
						ptr_q   <= rt_root;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						energy_sum              <= tot_e_q[emac_pkg::E_SUM_W-1:0];
						px_sum                  <= tot_px_q;
						py_sum                  <= tot_py_q;
						pz_sum                  <= tot_pz_q;
						mass_squared            <= m2_q[emac_pkg::M2_W-1:0];
						mass_signed             <= mroot_q[emac_pkg::MS_W-1:0];
						transverse_mass_squared <= mt2_q[emac_pkg::MT2_W-1:0];
						transverse_momentum     <= ptr_q[emac_pkg::PT_W-1:0];
						overflow                <= drop_q;
						tot_e_q                 <= '0;
						tot_px_q                <= '0;
						tot_py_q                <= '0;
						tot_pz_q                <= '0;
						vis_e_q                 <= '0;
						vis_pz_q                <= '0;
						inv_q                   <= '0;
						drop_q                  <= 1'b0;
						state_q                 <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rt_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		rt_start |-> !rt_stat.busy) else $error("root unit restarted while busy");
	a_rt_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rt_stat.done |-> (state_q == S_I3 || state_q == S_F7 ||
		                  state_q == S_F9W || state_q == S_F11))
		else $error("root finished outside a wait step");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("stalled result lost");

endmodule

// ===== hdl/event_mass_accumulator_top.sv =====
// Event mass accumulator.
// Input channel (in_valid / in_stall): one four-vector per beat with its kind
// (visible or invisible) and a last_vector mark that closes the event.
// Output channel (out_valid / out_stall): one result beat per event, carrying
// the summed components, squared and signed invariant mass, squared
// transverse mass, transverse momentum and the overflow mark.
// A two-entry queue sits between the input classifier and the sequencer, so
// the input keeps taking beats while the back end is busy or the output
// is stalled, until the queue is full.
// In the sequencer a visible vector is summed in its idle step; an invisible
// vector also waits for the bit-serial square root unit (29 iterations)
// behind the shared squarer, and no further vector is popped meanwhile.
// Closing an event takes three root extractions plus the squarer steps.
// Vectors past MAX_VECTORS in one event are dropped and flagged.
// Reset clears all sums, the queue and the output valid. A stalled result
// holds in the output register; the sequencer waits in its emit step
// while the queue keeps filling.
module event_mass_accumulator_top #(
	parameter int MAX_VECTORS    = 16,
	parameter int COMPONENT_BITS = 24
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_stall,
	input  logic                                        kind,
	input  logic [COMPONENT_BITS-2:0]                   energy,
	input  logic signed [COMPONENT_BITS-1:0]            mom_x,
	input  logic signed [COMPONENT_BITS-1:0]            mom_y,
	input  logic signed [COMPONENT_BITS-1:0]            mom_z,
	input  logic                                        last_vector,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	output logic [emac_pkg::E_SUM_W-1:0]                energy_sum,
	output logic signed [emac_pkg::ACC_W-1:0]           px_sum,
	output logic signed [emac_pkg::ACC_W-1:0]           py_sum,
	output logic signed [emac_pkg::ACC_W-1:0]           pz_sum,
	output logic signed [emac_pkg::M2_W-1:0]            mass_squared,
	output logic signed [emac_pkg::MS_W-1:0]            mass_signed,
	output logic signed [emac_pkg::MT2_W-1:0]           transverse_mass_squared,
	output logic [emac_pkg::PT_W-1:0]                   transverse_momentum,
	output logic                                        overflow
);

	emac_pkg::qctl_t                  head;
	logic [COMPONENT_BITS-2:0]        head_e;
	logic signed [COMPONENT_BITS-1:0] head_px;
	logic signed [COMPONENT_BITS-1:0] head_py;
	logic signed [COMPONENT_BITS-1:0] head_pz;
	logic                             pop;

	emac_front #(
		.MAX_VECTORS    (MAX_VECTORS),
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.energy      (energy),
		.mom_x       (mom_x),
		.mom_y       (mom_y),
		.mom_z       (mom_z),
		.last_vector (last_vector),
		.head        (head),
		.head_e      (head_e),
		.head_px     (head_px),
		.head_py     (head_py),
		.head_pz     (head_pz),
		.pop         (pop)
	);

	emac_back #(
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_back (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.head                    (head),
		.head_e                  (head_e),
		.head_px                 (head_px),
		.head_py                 (head_py),
		.head_pz                 (head_pz),
		.pop                     (pop),
		.out_valid               (out_valid),
		.out_stall               (out_stall),
		.energy_sum              (energy_sum),
		.px_sum                  (px_sum),
		.py_sum                  (py_sum),
		.pz_sum                  (pz_sum),
		.mass_squared            (mass_squared),
		.mass_signed             (mass_signed),
		.transverse_mass_squared (transverse_mass_squared),
		.transverse_momentum     (transverse_momentum),
		.overflow                (overflow)
	);

endmodule

// ===== verif/tb_event_mass_accumulator_top.sv =====
module tb_event_mass_accumulator_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_VEC = 16;
	localparam int CB      = 24;

	// one result beat, at port widths
	typedef struct {
		logic [emac_pkg::E_SUM_W-1:0]       e_sum;
		logic signed [emac_pkg::ACC_W-1:0]  px;
		logic signed [emac_pkg::ACC_W-1:0]  py;
		logic signed [emac_pkg::ACC_W-1:0]  pz;
		logic signed [emac_pkg::M2_W-1:0]   m2;
		logic signed [emac_pkg::MS_W-1:0]   ms;
		logic signed [emac_pkg::MT2_W-1:0]  mt2;
		logic [emac_pkg::PT_W-1:0]          pt;
		logic                               ov;
	} mass_res_t;

	// one input vector
	typedef struct {
		logic                 knd;
		logic [CB-2:0]        e;
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
		logic                 lst;
	} vec_t;

	// directed row: repeated rep times, last mark only on the final copy
	typedef struct {
		vec_t      v;
		int        rep;
		bit        typed;
		mass_res_t res;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, kind, last_vector;
	logic [CB-2:0] energy;
	logic signed [CB-1:0] mom_x, mom_y, mom_z;
	logic out_valid, out_stall;
	logic [emac_pkg::E_SUM_W-1:0] energy_sum;
	logic signed [emac_pkg::ACC_W-1:0] px_sum, py_sum, pz_sum;
	logic signed [emac_pkg::M2_W-1:0] mass_squared;
	logic signed [emac_pkg::MS_W-1:0] mass_signed;
	logic signed [emac_pkg::MT2_W-1:0] transverse_mass_squared;
	logic [emac_pkg::PT_W-1:0] transverse_momentum;
	logic overflow;

	event_mass_accumulator_top #(.MAX_VECTORS(MAX_VEC), .COMPONENT_BITS(CB)) dut (.*);

	// event sums kept by the predictor
	logic [emac_pkg::ACC_W-1:0] sum_e, sum_x, sum_y, sum_z, vis_e, vis_z, inv_mt;
	int unsigned n_vec;
	bit dropped;

	mass_res_t mass_q[$];
	int n_fail, n_events, n_ovf_events, n_beats;
	bit idle_on, hold_req;

	// floor square root, one result bit per step
	function automatic longint unsigned floor_root(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint signed_root(longint d);
		if (d < 0) return -longint'(floor_root(-d));
		return longint'(floor_root(d));
	endfunction

	function automatic longint acc_s(logic [emac_pkg::ACC_W-1:0] v);
		return longint'($signed(v));
	endfunction

	function automatic void clear_sums();
		sum_e = '0; sum_x = '0; sum_y = '0; sum_z = '0;
		vis_e = '0; vis_z = '0; inv_mt = '0;
		n_vec = 0;
		dropped = 0;
	endfunction

	// advance the event state by one vector; returns 1 with a result on last
	function automatic bit mass_step(vec_t v, output mass_res_t r);
		longint e, z, se, sx, sy, sz, pt2, m2, et;
		e = longint'(v.e);
		z = longint'(v.z);
		if (n_vec >= MAX_VEC) begin
			dropped = 1;
		end else begin
			n_vec++;
			sum_e += emac_pkg::ACC_W'(e);
			sum_x += emac_pkg::ACC_W'(longint'(v.x));
			sum_y += emac_pkg::ACC_W'(longint'(v.y));
			sum_z += emac_pkg::ACC_W'(z);
			if (v.knd == emac_pkg::KIND_INVISIBLE) begin
				inv_mt += emac_pkg::ACC_W'(signed_root(e * e - z * z));
			end else begin
				vis_e += emac_pkg::ACC_W'(e);
				vis_z += emac_pkg::ACC_W'(z);
			end
		end
		if (!v.lst) return 0;
		se = longint'(sum_e);
		sx = acc_s(sum_x);
		sy = acc_s(sum_y);
		sz = acc_s(sum_z);
		pt2 = sx * sx + sy * sy;
		m2 = se * se - pt2 - sz * sz;
		et = signed_root(longint'(vis_e) * longint'(vis_e) - acc_s(vis_z) * acc_s(vis_z))
			+ acc_s(inv_mt);
		r.e_sum = emac_pkg::E_SUM_W'(se);
		r.px = emac_pkg::ACC_W'(sx);
		r.py = emac_pkg::ACC_W'(sy);
		r.pz = emac_pkg::ACC_W'(sz);
		r.m2 = emac_pkg::M2_W'(m2);
		r.ms = emac_pkg::MS_W'(signed_root(m2));
		r.mt2 = emac_pkg::MT2_W'(et * et - pt2);
		r.pt = emac_pkg::PT_W'(floor_root(pt2));
		r.ov = dropped;
		clear_sums();
		return 1;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("event_mass_accumulator_top: mismatch");
		$finish;
	end

	// drive one beat; predict at the accepting edge
	task automatic put_vec(vec_t v, bit typed, mass_res_t tres);
		mass_res_t r;
		if (idle_on && $urandom_range(99) < 18) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1;
		kind <= v.knd;
		energy <= v.e;
		mom_x <= v.x;
		mom_y <= v.y;
		mom_z <= v.z;
		last_vector <= v.lst;
		do @(posedge clk); while (in_stall);
		n_beats++;
		if (mass_step(v, r)) begin
			if (r.ov) n_ovf_events++;
			mass_q.push_back(typed ? tres : r);
		end
		@(negedge clk);
	endtask

	function automatic logic [CB-1:0] rnd_comp();
		case ($urandom_range(3))
			0: return $urandom_range(1, 0) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
			1: return CB'($signed($urandom_range(2000)) - 1000);
			default: return CB'($urandom);
		endcase
	endfunction

	// result receiver: random stalls, plus one long hold-off on request
	initial begin
		out_stall = 1;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (300) @(negedge clk);
				hold_req = 0;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < 18);
			end
		end
	end

	task automatic chk(string name, longint exp_v, longint act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			n_fail++;
		end
	endtask

	// result checker
	initial begin
		mass_res_t x;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (mass_q.size() == 0) begin
					$error("result beat with no event pending");
					n_fail++;
				end else begin
					x = mass_q.pop_front();
					n_events++;
					chk("energy_sum", longint'(x.e_sum), longint'(energy_sum));
					chk("px_sum", longint'(x.px), longint'(px_sum));
					chk("py_sum", longint'(x.py), longint'(py_sum));
					chk("pz_sum", longint'(x.pz), longint'(pz_sum));
					chk("mass_squared", longint'(x.m2), longint'(mass_squared));
					chk("mass_signed", longint'(x.ms), longint'(mass_signed));
					chk("transverse_mass_squared", longint'(x.mt2),
						longint'(transverse_mass_squared));
					chk("transverse_momentum", longint'(x.pt), longint'(transverse_momentum));
					chk("overflow", longint'(x.ov), longint'(overflow));
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		vec_t v;
		mass_res_t none;
		int len, k;

		arst_n = 0;
		in_valid = 0;
		kind = 0; energy = '0; mom_x = '0; mom_y = '0; mom_z = '0; last_vector = 0;
		idle_on = 1;
		hold_req = 0;
		n_fail = 0; n_events = 0; n_ovf_events = 0; n_beats = 0;
		none = '{default: '0};
		clear_sums();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed table: single- and multi-vector events, extremes, overflow
		rows = '{
			'{'{emac_pkg::KIND_VISIBLE, 23'd3, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1, 1,
				'{27'd3, 28'sd0, 28'sd0, 28'sd0, 57'sd9, 29'sd3, 56'sd9, 28'd0, 1'b0}},
			'{'{emac_pkg::KIND_VISIBLE, 23'd0, 24'sd3, 24'sd4, 24'sd0, 1'b1}, 1, 1,
				'{27'd0, 28'sd3, 28'sd4, 28'sd0, -57'sd25, -29'sd5, -56'sd25, 28'd5, 1'b0}},
			'{'{emac_pkg::KIND_INVISIBLE, 23'd5, 24'sd0, 24'sd0, 24'sd3, 1'b1}, 1, 1,
				'{27'd5, 28'sd0, 28'sd0, 28'sd3, 57'sd16, 29'sd4, 56'sd16, 28'd0, 1'b0}},
			'{'{emac_pkg::KIND_VISIBLE, 23'h7fffff, 24'sh7fffff, -24'sh800000,
				-24'sh800000, 1'b0}, 1, 0, none},
			'{'{emac_pkg::KIND_INVISIBLE, 23'h7fffff, 24'sd0, 24'sd0, 24'sh7fffff, 1'b1},
				1, 0, none},
			'{'{emac_pkg::KIND_INVISIBLE, 23'd0, 24'sd0, 24'sd0, -24'sh800000, 1'b1},
				1, 0, none},
			'{'{emac_pkg::KIND_VISIBLE, 23'h7fffff, -24'sh800000, 24'sh7fffff,
				24'sh7fffff, 1'b1}, 17, 0, none},
			'{'{emac_pkg::KIND_INVISIBLE, 23'd100, 24'sd7, -24'sd9, 24'sd200, 1'b0},
				1, 0, none},
			'{'{emac_pkg::KIND_VISIBLE, 23'd50, -24'sd1, 24'sd1, -24'sd60, 1'b0},
				1, 0, none},
			'{'{emac_pkg::KIND_INVISIBLE, 23'd40, 24'sd0, 24'sd0, -24'sd30, 1'b1},
				1, 0, none}
		};
		foreach (rows[i]) begin
			rw = rows[i];
			for (k = 0; k < rw.rep; k++) begin
				v = rw.v;
				v.lst = (k == rw.rep - 1) ? rw.v.lst : 1'b0;
				put_vec(v, rw.typed && k == rw.rep - 1, rw.res);
			end
		end

		// random events, mostly short, some past the vector limit
		while (n_beats < 1350) begin
			if (n_beats >= 300 && n_beats < 500) idle_on = 0;
			else idle_on = 1;
			if (n_beats >= 700 && n_beats < 706) hold_req = 1;
			if (n_beats >= 1000 && n_beats < 1006 && mass_q.size() != 0) begin
				in_valid <= 0;
				wait (mass_q.size() == 0);
				@(negedge clk);
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
			for (k = 0; k < len; k++) begin
				v.knd = $urandom_range(1);
				if ($urandom_range(3) == 0)
					v.e = $urandom_range(1, 0) ? {(CB-1){1'b1}} : {(CB-1){1'b0}};
				else
					v.e = (CB-1)'($urandom);
				v.x = rnd_comp();
				v.y = rnd_comp();
				v.z = rnd_comp();
				v.lst = (k == len - 1);
				put_vec(v, 0, none);
			end
		end
		in_valid <= 0;
		idle_on = 0;

		wait (mass_q.size() == 0);
		repeat (1000) @(posedge clk);
		$display("covered %0d vectors in %0d events, %0d of them past the vector limit",
			n_beats, n_events, n_ovf_events);
		if (n_fail == 0 && mass_q.size() == 0)
			$display("event_mass_accumulator_top: match");
		else
			$display("event_mass_accumulator_top: mismatch");
		$finish;
	end

endmodule
